/* hdl/indexed_list_insert_delete_assert.svh */
// assertion macros for the indexed list block
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ILID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ILID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ilid_pkg.sv */
// shared types and command codes of the indexed list block
package ilid_pkg;

  localparam int POS_W       = 7;
  localparam int IO_VALUE_W  = 32;
  localparam int OUT_COUNT_W = 7;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [POS_W-1:0]      position;
    logic [IO_VALUE_W-1:0] item_value;
  } ilid_req_t;

  typedef struct packed {
    logic                   ok;
    logic [IO_VALUE_W-1:0]  read_value;
    logic [OUT_COUNT_W-1:0] entry_count;
  } ilid_resp_t;

  // broadcast to every cell, already qualified by range checks
  typedef struct packed {
    logic             do_insert;
    logic             do_delete;
    logic             do_get;
    logic [POS_W-1:0] position;
  } ilid_cell_ctrl_t;

  // result fields that travel beside the read tree
  typedef struct packed {
    logic                   ok;
    logic [OUT_COUNT_W-1:0] entry_count;
  } ilid_side_t;

endpackage

/* hdl/ilid_cell.sv */
// one list slot: holds an entry and shifts with its neighbors
module ilid_cell
  import ilid_pkg::*;
#(
  parameter int unsigned INDEX       = 0,
  parameter int          VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  ilid_cell_ctrl_t        ctrl,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [VALUE_WIDTH-1:0] right_value,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic [VALUE_WIDTH-1:0] read_leaf
);

  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   hit;
  logic                   above;

  assign hit   = (32'(ctrl.position) == INDEX);
  assign above = (32'(ctrl.position) < INDEX);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.do_insert) begin
      if (hit) begin
        value_nxt = new_value;
      end else if (above) begin
        value_nxt = left_value;
      end
    end else if (ctrl.do_delete) begin
      if (hit || above) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o   = value_r;
  assign read_leaf = (ctrl.do_get && hit) ? value_r : '0;

endmodule

/* hdl/ilid_read_tree.sv */
// registered 4-way or-reduction of the cell read leaves
module ilid_read_tree
  import ilid_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  logic                   in_fire,
  input  logic [VALUE_WIDTH-1:0] leaf [CAPACITY],
  input  ilid_side_t             side,
  output logic                   out_valid,
  output ilid_resp_t             out_data
);

  localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;

  logic [VALUE_WIDTH-1:0] src      [LEVELS][CAPACITY];
  logic [VALUE_WIDTH-1:0] node_nxt [LEVELS][CAPACITY];
  logic [VALUE_WIDTH-1:0] node_r   [LEVELS][CAPACITY];
  logic                   valid_r  [LEVELS];
  ilid_side_t             side_r   [LEVELS];

  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      for (int j = 0; j < CAPACITY; j++) begin
        if (k == 0) begin
          src[k][j] = leaf[j];
        end else begin
          src[k][j] = node_r[k-1][j];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      for (int j = 0; j < CAPACITY; j++) begin
        node_nxt[k][j] = '0;
        if (j <= ((CAPACITY - 1) >> (2 * (k + 1)))) begin
          for (int c = 0; c < 4; c++) begin
            if ((4 * j + c) < CAPACITY) begin
              node_nxt[k][j] = node_nxt[k][j] | src[k][4 * j + c];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < LEVELS; k++) begin
        for (int j = 0; j < CAPACITY; j++) begin
          node_r[k][j] <= node_nxt[k][j];
        end
        if (k == 0) begin
          side_r[k] <= side;
        end else begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LEVELS; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else if (advance) begin
      for (int k = 0; k < LEVELS; k++) begin
        if (k == 0) begin
          valid_r[k] <= in_fire;
        end else begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign out_valid            = valid_r[LEVELS-1];
  assign out_data.ok          = side_r[LEVELS-1].ok;
  assign out_data.entry_count = side_r[LEVELS-1].entry_count;
  assign out_data.read_value  = IO_VALUE_W'(node_r[LEVELS-1][0]);

endmodule

/* hdl/indexed_list_insert_delete.sv */
// top level of the indexed list: cell chain, count register and read tree
// Ordered list of up to CAPACITY entries addressed by position. Every input
// transaction (insert, delete or get) is applied to all cells at once: they
// shift together, so the block accepts one transaction per clock while the
// result path is free. Each result passes through the registered 4-way
// or-tree that gathers the addressed entry for a get. Results come out in
// input order and the tree stalls as a whole while a finished result waits
// with out_ready low. Entries need no clearing after reset; only the entry
// count and the result valid flags are reset.
`include "indexed_list_insert_delete_assert.svh"

module indexed_list_insert_delete
  import ilid_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ilid_req_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ilid_resp_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]          count_r, count_nxt;
  logic [PW-1:0]          pos_w;
  logic [PW-1:0]          cnt_w;
  logic                   advance;
  logic                   in_fire;
  logic                   ins_ok;
  logic                   del_ok;
  logic                   get_ok;
  ilid_cell_ctrl_t        ctrl;
  ilid_side_t             side;
  logic [VALUE_WIDTH-1:0] new_value;
  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [VALUE_WIDTH-1:0] leaf       [CAPACITY];

  // the whole pipe moves unless a finished result sits unread
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign in_fire  = in_valid && advance;

  assign pos_w = PW'(in_data.position);
  assign cnt_w = PW'(count_r);

  // range checks; an unused command code falls through as a failed no-op
  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    get_ok = 1'b0;
    case (in_data.cmd)
      CMD_INSERT: begin
        ins_ok = (pos_w <= cnt_w) && (count_r != CW'(CAPACITY));
      end
      CMD_DELETE: begin
        del_ok = (pos_w < cnt_w);
      end
      CMD_GET: begin
        get_ok = (pos_w < cnt_w);
      end
      default: begin
        ins_ok = 1'b0;
      end
    endcase
  end

  // broadcast to the cells, only for accepted transactions
  assign ctrl.do_insert = in_fire && ins_ok;
  assign ctrl.do_delete = in_fire && del_ok;
  assign ctrl.do_get    = in_fire && get_ok;
  assign ctrl.position  = in_data.position;

  // stored values keep the low VALUE_WIDTH bits
  assign new_value = VALUE_WIDTH'(in_data.item_value);

  always_comb begin
    count_nxt = count_r;
    if (ctrl.do_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.do_delete) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result fields other than the read value ride beside the tree
  assign side.ok          = ins_ok || del_ok || get_ok;
  assign side.entry_count = OUT_COUNT_W'(count_nxt);

  // chain of cells; the end cells see zero where no neighbor exists
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v;
    logic [VALUE_WIDTH-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end

    ilid_cell #(
      .INDEX       (i),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (new_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value_o     (cell_value[i]),
      .read_leaf   (leaf[i])
    );
  end

  // gathers the addressed entry; zero unless a get succeeded
  ilid_read_tree #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_fire   (in_fire),
    .leaf      (leaf),
    .side      (side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // count stays within the list bounds
  `ILID_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "entry count above capacity")
  // a failed or read-only transaction leaves the count alone
  `ILID_ASSERT_NEXT(a_fail_keeps, in_fire && !ins_ok && !del_ok,
                    $stable(count_r), "count moved without insert or delete")
  // a good insert grows the list by one
  `ILID_ASSERT_NEXT(a_ins_grow, in_fire && ins_ok,
                    count_r == $past(count_r) + CW'(1), "insert did not grow count")
  // a good delete shrinks the list by one
  `ILID_ASSERT_NEXT(a_del_shrink, in_fire && del_ok,
                    count_r == $past(count_r) - CW'(1), "delete did not shrink count")

endmodule
